// File: rtl/efg_pkg.sv
package efg_pkg;

    localparam int ID_W      = 6;
    localparam int ARG_W     = 64;
    localparam int MASK_W    = 63;
    localparam int MAX_SLOTS = 63;

    typedef enum logic [2:0] {
        OP_SEND        = 3'd0,
        OP_CLEAR       = 3'd1,
        OP_GET         = 3'd2,
        OP_TAKE_ARG    = 3'd3,
        OP_TAKE_LOWEST = 3'd4,
        OP_TAKE_ID     = 3'd5,
        OP_TAKE_MASKED = 3'd6
    } efg_op_t;

    typedef struct packed {
        efg_op_t            op;
        logic [ID_W-1:0]    id;
        logic [MASK_W-1:0]  mask;
    } efg_cmd_t;

    typedef struct packed {
        logic               found;
        logic [ID_W-1:0]    taken_id;
    } efg_flag_res_t;

endpackage

// File: rtl/efg_arg_store.sv
module efg_arg_store
    import efg_pkg::*;
#(
    parameter int DEPTH  = 63,
    parameter int WIDTH  = 64,
    parameter int ADDR_W = 6
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [WIDTH-1:0] rd_data_reg;

    // entries never written read as the null argument
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr_en)
        begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read returns the value before a same-cycle write
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= valid_reg[rd_addr] ? mem[rd_addr] : '0;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/efg_flag_unit.sv
module efg_flag_unit
    import efg_pkg::*;
#(
    parameter int NUM_SLOTS = 63
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          advance,
    input  efg_cmd_t      cmd,
    output efg_flag_res_t result
);

    logic [NUM_SLOTS-1:0] flags_reg;
    logic [NUM_SLOTS-1:0] flags_next;
    logic [NUM_SLOTS-1:0] id_bit;
    logic [NUM_SLOTS-1:0] sel;
    logic [NUM_SLOTS-1:0] cand;
    logic [NUM_SLOTS-1:0] lowest;
    logic [ID_W-1:0]      low_id;
    logic                 id_ok;

    assign id_ok  = (cmd.id != '0) && (cmd.id <= ID_W'(NUM_SLOTS));
    assign id_bit = NUM_SLOTS'(1) << (cmd.id - ID_W'(1));
    assign sel    = (cmd.op == OP_TAKE_LOWEST) ? '1 : cmd.mask[NUM_SLOTS-1:0];
    assign cand   = sel & flags_reg;
    // isolate lowest set bit
    assign lowest = cand & (~cand + NUM_SLOTS'(1));

    always_comb
    begin
        low_id = '0;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            low_id = low_id | (lowest[i] ? ID_W'(i + 1) : '0);
        end
    end

    always_comb
    begin
        flags_next = flags_reg;
        result     = '0;
        unique case (cmd.op)
            OP_SEND:
            begin
                if (id_ok)
                begin
                    flags_next = flags_reg | id_bit;
                end
            end
            OP_CLEAR:
            begin
                flags_next = '0;
            end
            OP_TAKE_LOWEST, OP_TAKE_MASKED:
            begin
                if (|cand)
                begin
                    flags_next      = flags_reg & ~lowest;
                    result.found    = 1'b1;
                    result.taken_id = low_id;
                end
            end
            OP_TAKE_ID:
            begin
                if (id_ok && |(flags_reg & id_bit))
                begin
                    flags_next      = flags_reg & ~id_bit;
                    result.found    = 1'b1;
                    result.taken_id = cmd.id;
                end
            end
            OP_GET, OP_TAKE_ARG:
            begin
                flags_next = flags_reg;
            end
            default:
            begin
                flags_next = flags_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '0;
        end
        else if (advance)
        begin
            flags_reg <= flags_next;
        end
    end

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        advance && cmd.op == OP_CLEAR |=> flags_reg == '0)
        else $error("flags not empty after clear");

    a_take_drops_one: assert property (@(posedge clk) disable iff (!rst_n)
        advance && result.found |=>
            $countones(flags_reg) == $past($countones(flags_reg)) - 1)
        else $error("take did not drop exactly one flag");

    a_flags_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(flags_reg))
        else $error("flags changed without a transaction");

endmodule

// File: rtl/event_flag_group.sv
// Event flag group: pending flags for event ids 1..EVENT_LIMIT-1 (at most 63)
// with one argument word per id. One transaction is accepted per clock while
// the result is not stalled, and it passes through the input stage and the
// result register: the argument memory is read and written at the accepting
// edge (one write, one registered read), flags are priority-encoded from the
// input stage and updated when it advances, and the result register drives the
// output. A stalled result holds the input stage, which then holds the input.
// Argument entries read as zero until written;
// per-entry valid bits clear at reset, so no clearing pass is needed and
// the block is ready right out of reset. Send, get, take-arg and take-id with
// id 0 or an out-of-range id change nothing and answer zero; op code 7 is a no-op.
module event_flag_group
    import efg_pkg::*;
#(
    parameter int EVENT_LIMIT = 64,
    parameter int ARG_WIDTH   = 64
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [135:0] s_tdata,  // event_id[5:0], arg_value[69:6], id_mask[132:70]
    input  logic [2:0]   s_tuser,  // operation[2:0]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [71:0]  m_tdata,  // taken_id[5:0], arg_out[69:6]
    output logic [0:0]   m_tuser   // found[0]
);

    localparam int NUM_SLOTS = (EVENT_LIMIT - 1 > MAX_SLOTS) ? MAX_SLOTS : EVENT_LIMIT - 1;
    localparam int ADDR_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    efg_cmd_t         in_cmd;
    logic [ARG_W-1:0] in_arg;
    logic             in_id_ok;
    logic             accept;
    logic             advance;
    logic             mem_wr_en;
    logic             mem_rd_en;
    logic [ADDR_W-1:0] mem_addr;
    logic [ARG_WIDTH-1:0] mem_wr_data;
    logic [ARG_WIDTH-1:0] mem_rd_data;

    logic             a_valid_reg;
    efg_cmd_t         a_cmd_reg;
    logic             a_arg_sel_reg;
    efg_flag_res_t    flag_res;

    logic             m_tvalid_reg;
    logic             m_found_reg;
    logic [ID_W-1:0]  m_taken_reg;
    logic [ARG_W-1:0] m_arg_reg;

    assign in_cmd.op   = efg_op_t'(s_tuser);
    assign in_cmd.id   = s_tdata[5:0];
    assign in_cmd.mask = s_tdata[132:70];
    assign in_arg      = s_tdata[69:6];

    assign in_id_ok = (in_cmd.id != '0) && (in_cmd.id <= ID_W'(NUM_SLOTS));

    assign advance  = a_valid_reg && (!m_tvalid_reg || m_tready);
    assign s_tready = !a_valid_reg || advance;
    assign accept   = s_tvalid && s_tready;

    // argument store is touched at the accepting edge; take arg reads old, writes zero
    assign mem_addr    = ADDR_W'(in_cmd.id - ID_W'(1));
    assign mem_wr_en   = accept && in_id_ok &&
                         (in_cmd.op == OP_SEND || in_cmd.op == OP_TAKE_ARG);
    assign mem_rd_en   = accept && in_id_ok &&
                         (in_cmd.op == OP_GET || in_cmd.op == OP_TAKE_ARG);
    assign mem_wr_data = (in_cmd.op == OP_SEND) ? in_arg[ARG_WIDTH-1:0] : '0;

    efg_arg_store #(
        .DEPTH  (NUM_SLOTS),
        .WIDTH  (ARG_WIDTH),
        .ADDR_W (ADDR_W)
    ) u_arg_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_addr),
        .rd_data (mem_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            a_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_cmd_reg     <= in_cmd;
            a_arg_sel_reg <= mem_rd_en;
        end
    end

    efg_flag_unit #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_flag_unit (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .cmd     (a_cmd_reg),
        .result  (flag_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (advance)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            m_found_reg <= flag_res.found;
            m_taken_reg <= flag_res.taken_id;
            m_arg_reg   <= a_arg_sel_reg ? ARG_W'(mem_rd_data) : '0;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = {2'b00, m_arg_reg, m_taken_reg};
    assign m_tuser[0] = m_found_reg;

    a_found_has_id: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid_reg && m_found_reg |-> m_taken_reg != '0)
        else $error("found result without an id");

    a_miss_no_id: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid_reg && !m_found_reg |-> m_taken_reg == '0)
        else $error("id reported without found");

    a_arg_not_take: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid_reg && m_arg_reg != '0 |-> !m_found_reg)
        else $error("argument returned with a flag take");

    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> a_valid_reg && m_tvalid_reg && !m_tready)
        else $error("input stalled with room in the pipe");

endmodule
